// ----- rtl/core/sci_pkg.sv -----
// Shared constants and types for the state-of-charge curve interpolator.
package sci_pkg;

  localparam int MAX_POINTS = 16;
  localparam int MIN_POINTS = 2;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int VOLT_W     = 13;
  localparam int SOC_W      = 8;
  localparam int CELLV_W    = 16;
  localparam int PCT_W      = 7;
  localparam int PROD_W     = VOLT_W + PCT_W;

  localparam logic [VOLT_W-1:0] VOLT_MIN = VOLT_W'(2000);
  localparam logic [VOLT_W-1:0] VOLT_MAX = VOLT_W'(5000);
  localparam logic signed [SOC_W-1:0] SOC_MAX = SOC_W'(100);

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Lookup record that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic                     active;
    logic                     ok;
    logic                     found;
    logic                     direct;
    logic [VOLT_W-1:0]        prev_v;
    logic signed [SOC_W-1:0]  prev_s;
    logic signed [SOC_W-1:0]  s0;
    logic [VOLT_W-1:0]        dx;
    logic [VOLT_W-1:0]        dv;
    logic [SOC_W-1:0]         ds;
  } wave_t;

endpackage

// ----- rtl/core/sci_cell.sv -----
// One curve point cell: stores a point, checks it and tests the lookup voltage.
module sci_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [sci_pkg::IDX_W-1:0]          idx_i,
  input  logic [sci_pkg::CNT_W-1:0]          count_i,
  input  logic [sci_pkg::CELLV_W-1:0]        cell_v_i,
  input  logic                               wr_en_i,
  input  logic [sci_pkg::VOLT_W-1:0]         wr_v_i,
  input  logic signed [sci_pkg::SOC_W-1:0]   wr_s_i,
  input  sci_pkg::wave_t                     wave_i,
  output sci_pkg::wave_t                     wave_o
);
  import sci_pkg::*;

  logic [VOLT_W-1:0]       v_q;
  logic signed [SOC_W-1:0] s_q;
  wave_t                   wave_d, wave_q;
  logic                    first, in_use, range_ok, order_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      s_q <= '0;
    end else if (wr_en_i) begin
      v_q <= wr_v_i;
      s_q <= wr_s_i;
    end
  end

  assign first    = (idx_i == '0);
  assign in_use   = ({1'b0, idx_i} < count_i);
  assign range_ok = (v_q >= VOLT_MIN) && (v_q <= VOLT_MAX) && !s_q[SOC_W-1] && (s_q <= SOC_MAX);
  assign order_ok = first || ((v_q > wave_i.prev_v) && (s_q >= wave_i.prev_s));

  always_comb begin
    wave_d = wave_i;
    if (wave_i.active && in_use) begin
      wave_d.ok = wave_i.ok & range_ok & order_ok;
      if (!wave_i.found && (cell_v_i <= {{(CELLV_W-VOLT_W){1'b0}}, v_q})) begin
        wave_d.found  = 1'b1;
        wave_d.direct = first;
        wave_d.s0     = first ? s_q : wave_i.prev_s;
        wave_d.dx     = cell_v_i[VOLT_W-1:0] - wave_i.prev_v;
        wave_d.dv     = v_q - wave_i.prev_v;
        wave_d.ds     = s_q - wave_i.prev_s;
      end
      wave_d.prev_v = v_q;
      wave_d.prev_s = s_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;

endmodule

// ----- rtl/core/sci_div.sv -----
// Restoring divider, one quotient bit per cycle.
module sci_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sci_pkg::PROD_W-1:0]   dividend_i,
  input  logic [sci_pkg::VOLT_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [sci_pkg::PCT_W-1:0]    quotient_o
);
  import sci_pkg::*;

  localparam int STEP_W = $clog2(PROD_W);

  logic                busy_q, done_q;
  logic [STEP_W-1:0]   step_q;
  logic [PROD_W-1:0]   quo_q;
  logic [VOLT_W-1:0]   rem_q, dvs_q;
  logic [VOLT_W:0]     trial;
  logic                fits;

  assign trial = {rem_q, quo_q[PROD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(PROD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? VOLT_W'(trial - {1'b0, dvs_q}) : trial[VOLT_W-1:0];
      quo_q <= {quo_q[PROD_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[PCT_W-1:0];

endmodule

// ----- rtl/core/soc_curve_interpolator.sv -----
// Top level: state-of-charge curve interpolator built as a row of point cells.
// A point write gives no result. A lookup gives its result after the 16-cell walk on an
//   invalid curve or a clamped voltage, and after the walk, a multiply and a 20-step divide
//   when it interpolates.
// Throughput: one lookup at a time; busy stays high until the result cycle, so the next
//   transaction waits for the lookup's result; point writes go every cycle while idle.
// The receiver cannot stall: done_o marks a one-cycle result.
// Reset (rst_ni low, async): curve points and point_count clear to zero, block idle.
module soc_curve_interpolator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind_i,
  input  logic [sci_pkg::IDX_W-1:0]          point_index_i,
  input  logic [sci_pkg::VOLT_W-1:0]         point_voltage_mv_i,
  input  logic signed [sci_pkg::SOC_W-1:0]   point_soc_i,
  input  logic [sci_pkg::CELLV_W-1:0]        cell_voltage_mv_i,
  input  logic                               point_count_we_i,
  input  logic [sci_pkg::CNT_W-1:0]          point_count_i,
  output logic                               done_o,
  output logic [sci_pkg::PCT_W-1:0]          soc_percent_o,
  output logic                               curve_valid_o
);
  import sci_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q;
  logic [CELLV_W-1:0]  cell_v_q;
  wave_t               chain [MAX_POINTS+1];
  wave_t               inject;
  wave_t               seg_q;
  logic                accept, wr_accept, lk_accept, count_ok;
  logic                launch_q;
  logic [PROD_W-1:0]   prod_q;
  logic                div_start, div_done;
  logic [PCT_W-1:0]    quotient;
  logic                done_q, valid_q;
  logic [PCT_W-1:0]    pct_q;

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign wr_accept = accept && (kind_i == KIND_WRITE);
  assign lk_accept = accept && (kind_i == KIND_LOOKUP);
  assign count_ok  = (count_q >= CNT_W'(MIN_POINTS)) && (count_q <= CNT_W'(MAX_POINTS));

  // point_count register, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (point_count_we_i) begin
      count_q <= point_count_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_accept) begin
      cell_v_q <= cell_voltage_mv_i;
    end
  end

  // Lookup record enters cell 0 on the cycle after the lookup is taken,
  // so cells compare against the latched cell voltage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= 1'b0;
    end else begin
      launch_q <= lk_accept;
    end
  end

  always_comb begin
    inject        = '0;
    inject.active = launch_q;
    inject.ok     = count_ok;
  end

  assign chain[0] = inject;

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    sci_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (IDX_W'(g)),
      .count_i  (count_q),
      .cell_v_i (cell_v_q),
      .wr_en_i  (wr_accept && (point_index_i == IDX_W'(g))),
      .wr_v_i   (point_voltage_mv_i),
      .wr_s_i   (point_soc_i),
      .wave_i   (chain[g]),
      .wave_o   (chain[g+1])
    );
  end

  // Sequencer: walk, then optional multiply and divide for interpolation.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (lk_accept) state_d = S_WALK;
      S_WALK: begin
        if (chain[MAX_POINTS].active) begin
          if (chain[MAX_POINTS].ok && chain[MAX_POINTS].found && !chain[MAX_POINTS].direct) begin
            state_d = S_MUL;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_MUL:  state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WALK && chain[MAX_POINTS].active) begin
      seg_q <= chain[MAX_POINTS];
    end
    if (state_q == S_MUL) begin
      // (cell - v0) * (s1 - s0); both factors are non-negative on a valid curve
      prod_q <= PROD_W'(seg_q.dx * seg_q.ds[PCT_W-1:0]);
    end
  end

  assign div_start = (state_q == S_MUL);

  sci_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ((state_q == S_MUL) ? PROD_W'(seg_q.dx * seg_q.ds[PCT_W-1:0]) : prod_q),
    .divisor_i  (seg_q.dv),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Result register: one-cycle strobe per lookup.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      valid_q <= 1'b0;
      pct_q   <= '0;
    end else if (state_q == S_WALK && chain[MAX_POINTS].active) begin
      if (!chain[MAX_POINTS].ok) begin
        done_q  <= 1'b1;
        valid_q <= 1'b0;
        pct_q   <= '0;
      end else if (!chain[MAX_POINTS].found) begin
        // above the last point: clamp to its charge
        done_q  <= 1'b1;
        valid_q <= 1'b1;
        pct_q   <= chain[MAX_POINTS].prev_s[PCT_W-1:0];
      end else if (chain[MAX_POINTS].direct) begin
        // at or below the first point
        done_q  <= 1'b1;
        valid_q <= 1'b1;
        pct_q   <= chain[MAX_POINTS].s0[PCT_W-1:0];
      end else begin
        done_q  <= 1'b0;
      end
    end else if (state_q == S_DIV && div_done) begin
      done_q  <= 1'b1;
      valid_q <= 1'b1;
      pct_q   <= seg_q.s0[PCT_W-1:0] + quotient;
    end else begin
      done_q  <= 1'b0;
    end
  end

  assign done_o        = done_q;
  assign soc_percent_o = pct_q;
  assign curve_valid_o = valid_q;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !curve_valid_o |-> soc_percent_o == '0)
    else $error("invalid curve result is not zero");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && curve_valid_o |-> soc_percent_o <= PCT_W'(100))
    else $error("charge above 100 percent");

  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lk_accept |=> busy)
    else $error("lookup accepted without going busy");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_accept |=> !done_o)
    else $error("point write produced a result");

  a_walk_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[MAX_POINTS].active |-> state_q == S_WALK)
    else $error("lookup record left the row outside the walk");
`endif

endmodule
